@@ rtl/ddd_pkg.sv @@
// Shared widths, constants and the month table for the date difference block.
// Depends on nothing; used by ddd_day_count and date_day_difference.
`default_nettype none

package ddd_pkg;

   // field widths
   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;
   localparam int DIFF_W  = 22;

   // day count of one date: 365 * 16383 plus leap days, month and day fit in 23 bits
   localparam int COUNT_W = 23;

   // default largest year taken as given; later years clamp to it
   localparam int MAX_YEAR = 9999;

   // saturation bound of the result
   localparam logic [COUNT_W-1:0] DIFF_MAX = COUNT_W'((1 << DIFF_W) - 1);

   // divide by 100 as multiply by 5243 and shift right by 19, exact below 2**14
   localparam int RECIP_W     = 13;
   localparam int RECIP_SHIFT = 19;
   localparam int PROD_W      = YEAR_W + RECIP_W;
   localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
   localparam logic [PROD_W-1:0] RECIP_100 = PROD_W'(5243);

   // leap day total of years 0 to year-1, and day count inside one year
   localparam int LEAPS_W = YEAR_W - 1;
   localparam int MPART_W = 10;
   localparam int MTAB_W  = 9;

   localparam logic [COUNT_W-1:0] DAYS_YEAR = COUNT_W'(365);
   localparam logic [YEAR_W-1:0]  CENTURY   = YEAR_W'(100);
   localparam logic [MONTH_W-1:0] FEBRUARY  = MONTH_W'(2);

   // days in the months before the given one; months past twelve count all twelve
   function automatic logic [MTAB_W-1:0] months_before(input logic [MONTH_W-1:0] month);
      logic [MTAB_W-1:0] days;
      case (month)
         4'd0:    days = 9'd0;
         4'd1:    days = 9'd0;
         4'd2:    days = 9'd31;
         4'd3:    days = 9'd59;
         4'd4:    days = 9'd90;
         4'd5:    days = 9'd120;
         4'd6:    days = 9'd151;
         4'd7:    days = 9'd181;
         4'd8:    days = 9'd212;
         4'd9:    days = 9'd243;
         4'd10:   days = 9'd273;
         4'd11:   days = 9'd304;
         4'd12:   days = 9'd334;
         default: days = 9'd365;
      endcase
      return days;
   endfunction

endpackage

`default_nettype wire

@@ rtl/date_day_difference.sv @@
// Top level of the Gregorian day difference block: two day count pipelines,
// absolute difference and saturating output register. Depends on ddd_pkg, ddd_day_count.
//
// Use: drive both dates on the req_ ports and raise start for one cycle per word.
// A word is taken at each rising edge with start high and busy low; busy stays low,
// so a new word may be taken in every cycle, one word per cycle sustained.
// Each word gives one result on rsp_day_difference, marked by rsp_strobe for
// exactly one cycle. It passes through five register stages: three form each day
// count (clamp and products, leap terms, sum), one holds the absolute difference,
// one saturates into the output register.
// The receiver cannot stall; results leave at the rate words arrive.
// Years above the maximum year clamp to it; days and months are not checked.
// Reset is synchronous and active high: it clears the valid bits of all stages,
// so words in flight are dropped and no strobe follows until new words arrive.
// The block keeps no state between words.
`default_nettype none

module date_day_difference #(
   parameter int MAX_YEAR = ddd_pkg::MAX_YEAR
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output      logic                          busy,
   input  wire logic [ddd_pkg::DAY_W-1:0]     req_first_day,
   input  wire logic [ddd_pkg::MONTH_W-1:0]   req_first_month,
   input  wire logic [ddd_pkg::YEAR_W-1:0]    req_first_year,
   input  wire logic [ddd_pkg::DAY_W-1:0]     req_second_day,
   input  wire logic [ddd_pkg::MONTH_W-1:0]   req_second_month,
   input  wire logic [ddd_pkg::YEAR_W-1:0]    req_second_year,
   output      logic                          rsp_strobe,
   output      logic [ddd_pkg::DIFF_W-1:0]    rsp_day_difference
);

   localparam int COUNT_STAGES = 3;

   // never hold off a word
   assign busy = 1'b0;

   // day counts of both dates
   logic [ddd_pkg::COUNT_W-1:0] first_count;
   logic [ddd_pkg::COUNT_W-1:0] second_count;

   ddd_day_count #(
      .MAX_YEAR (MAX_YEAR)
   ) u_first_count (
      .clock (clock),
      .day   (req_first_day),
      .month (req_first_month),
      .year  (req_first_year),
      .count (first_count)
   );

   ddd_day_count #(
      .MAX_YEAR (MAX_YEAR)
   ) u_second_count (
      .clock (clock),
      .day   (req_second_day),
      .month (req_second_month),
      .year  (req_second_year),
      .count (second_count)
   );

   // advance valid bits alongside the count pipelines
   logic [COUNT_STAGES-1:0] valid_ff, valid_in;

   assign valid_in = {valid_ff[COUNT_STAGES-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // absolute difference of the two counts
   logic [ddd_pkg::COUNT_W-1:0] diff_ff, diff_in;
   logic                        diff_valid_ff;

   assign diff_in = (first_count >= second_count) ? (first_count - second_count)
                                                  : (second_count - first_count);

   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
      if (reset) begin
         diff_valid_ff <= 1'b0;
      end else begin
         diff_valid_ff <= valid_ff[COUNT_STAGES-1];
      end
   end

   // saturate into the output register
   logic [ddd_pkg::DIFF_W-1:0] rsp_day_difference_ff, rsp_day_difference_in;
   logic                       rsp_strobe_ff;

   assign rsp_day_difference_in = (diff_ff > ddd_pkg::DIFF_MAX)
                                ? ddd_pkg::DIFF_MAX[ddd_pkg::DIFF_W-1:0]
                                : diff_ff[ddd_pkg::DIFF_W-1:0];

   always_ff @(posedge clock) begin
      rsp_day_difference_ff <= rsp_day_difference_in;
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= diff_valid_ff;
      end
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_day_difference = rsp_day_difference_ff;

   // a taken word gives its result strobe
   a_word_gives_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##5 rsp_strobe)
      else $error("taken word produced no result strobe");

   // no strobe without an earlier taken word
   a_no_invented_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 5))
      else $error("result strobe without a taken word");

   // the same date twice is zero days apart
   a_same_date_zero: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_first_day == req_second_day) &&
       (req_first_month == req_second_month) && (req_first_year == req_second_year))
      |-> ##5 (rsp_day_difference == '0))
      else $error("equal dates gave a nonzero difference");

endmodule

`default_nettype wire

@@ rtl/ddd_day_count.sv @@
// Three-stage pipeline that turns one date into its running day count.
// Depends on ddd_pkg for widths, constants and the month table.
`default_nettype none

module ddd_day_count #(
   parameter int MAX_YEAR = ddd_pkg::MAX_YEAR
) (
   input  wire logic                          clock,
   input  wire logic [ddd_pkg::DAY_W-1:0]     day,
   input  wire logic [ddd_pkg::MONTH_W-1:0]   month,
   input  wire logic [ddd_pkg::YEAR_W-1:0]    year,
   output      logic [ddd_pkg::COUNT_W-1:0]   count
);

   // largest year taken as given, bounded by the year field
   localparam int YEAR_TOP = (1 << ddd_pkg::YEAR_W) - 1;
   localparam logic [ddd_pkg::YEAR_W-1:0] CLAMP_YEAR =
      ddd_pkg::YEAR_W'(MAX_YEAR > YEAR_TOP ? YEAR_TOP : MAX_YEAR);

   // stage one: clamp, year length products, reciprocal products
   logic [ddd_pkg::YEAR_W-1:0]  year_c;
   logic                        year_nz;
   logic [ddd_pkg::YEAR_W-1:0]  prev_year;

   logic [ddd_pkg::YEAR_W-1:0]  year_ff;
   logic [ddd_pkg::YEAR_W-1:0]  prev_ff;
   logic                        year_nz_ff;
   logic [ddd_pkg::PROD_W-1:0]  prod_prev_ff, prod_prev_in;
   logic [ddd_pkg::PROD_W-1:0]  prod_year_ff, prod_year_in;
   logic [ddd_pkg::COUNT_W-1:0] y365_ff, y365_in;
   logic [ddd_pkg::MONTH_W-1:0] month_ff;
   logic [ddd_pkg::DAY_W-1:0]   day_ff;

   assign year_c    = (year > CLAMP_YEAR) ? CLAMP_YEAR : year;
   assign year_nz   = (year_c != '0);
   assign prev_year = year_nz ? (year_c - ddd_pkg::YEAR_W'(1)) : '0;

   assign prod_prev_in = ddd_pkg::PROD_W'(prev_year) * ddd_pkg::RECIP_100;
   assign prod_year_in = ddd_pkg::PROD_W'(year_c) * ddd_pkg::RECIP_100;
   assign y365_in      = ddd_pkg::COUNT_W'(year_c) * ddd_pkg::DAYS_YEAR;

   always_ff @(posedge clock) begin
      year_ff      <= year_c;
      prev_ff      <= prev_year;
      year_nz_ff   <= year_nz;
      prod_prev_ff <= prod_prev_in;
      prod_year_ff <= prod_year_in;
      y365_ff      <= y365_in;
      month_ff     <= month;
      day_ff       <= day;
   end

   // stage two: leap days before the year, leap test, days inside the year
   logic [ddd_pkg::QUOT_W-1:0]  prev_q100;
   logic [ddd_pkg::QUOT_W-1:0]  year_q100;
   logic                        year_div100;
   logic                        leap;
   logic                        extra_day;

   logic [ddd_pkg::LEAPS_W-1:0] leaps_ff, leaps_in;
   logic [ddd_pkg::MPART_W-1:0] mpart_ff, mpart_in;
   logic [ddd_pkg::COUNT_W-1:0] y365_s2_ff;

   assign prev_q100   = prod_prev_ff[ddd_pkg::PROD_W-1:ddd_pkg::RECIP_SHIFT];
   assign year_q100   = prod_year_ff[ddd_pkg::PROD_W-1:ddd_pkg::RECIP_SHIFT];
   assign year_div100 = (year_ff == ddd_pkg::YEAR_W'(year_q100) * ddd_pkg::CENTURY);
   // divisible by 400 when divisible by 100 with a quotient divisible by 4
   assign leap = ((year_ff[1:0] == 2'b00) && !year_div100) ||
                 (year_div100 && (year_q100[1:0] == 2'b00));
   assign extra_day = leap && (month_ff > ddd_pkg::FEBRUARY);

   // p/4 - p/100 + p/400 + 1, with p/400 as (p/100)/4
   assign leaps_in = ddd_pkg::LEAPS_W'(prev_ff[ddd_pkg::YEAR_W-1:2])
                   - ddd_pkg::LEAPS_W'(prev_q100)
                   + ddd_pkg::LEAPS_W'(prev_q100[ddd_pkg::QUOT_W-1:2])
                   + ddd_pkg::LEAPS_W'(year_nz_ff);

   assign mpart_in = ddd_pkg::MPART_W'(ddd_pkg::months_before(month_ff))
                   + ddd_pkg::MPART_W'(extra_day)
                   + ddd_pkg::MPART_W'(day_ff);

   always_ff @(posedge clock) begin
      leaps_ff   <= leaps_in;
      mpart_ff   <= mpart_in;
      y365_s2_ff <= y365_ff;
   end

   // stage three: sum the parts
   logic [ddd_pkg::COUNT_W-1:0] count_ff, count_in;

   assign count_in = y365_s2_ff + ddd_pkg::COUNT_W'(leaps_ff) + ddd_pkg::COUNT_W'(mpart_ff);

   always_ff @(posedge clock) begin
      count_ff <= count_in;
   end

   assign count = count_ff;

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking testbench for date_day_difference: random and directed date pairs
// go in, and a local day count model checks every difference. Depends on ddd_pkg.
`timescale 1ns / 100ps

module tb_top;

   localparam int RANDOM_WORDS  = 1650;
   localparam int SETTLE_CYCLES = 12;
   localparam int STALL_LIMIT   = 2000;
   localparam int DIFF_LIMIT    = (1 << ddd_pkg::DIFF_W) - 1;

   // days in the months before a given month; anything past twelve counts the full year
   localparam int DAYS_BEFORE_MONTH [0:13] =
      '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365};

   typedef struct packed {
      logic [ddd_pkg::DAY_W-1:0]   first_day;
      logic [ddd_pkg::MONTH_W-1:0] first_month;
      logic [ddd_pkg::YEAR_W-1:0]  first_year;
      logic [ddd_pkg::DAY_W-1:0]   second_day;
      logic [ddd_pkg::MONTH_W-1:0] second_month;
      logic [ddd_pkg::YEAR_W-1:0]  second_year;
   } date_pair_type;

   typedef struct {
      date_pair_type dates;
      int            idle_pct;
      bit            wait_for_drain;
   } pending_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [ddd_pkg::DAY_W-1:0]   req_first_day    = '0;
   logic [ddd_pkg::MONTH_W-1:0] req_first_month  = '0;
   logic [ddd_pkg::YEAR_W-1:0]  req_first_year   = '0;
   logic [ddd_pkg::DAY_W-1:0]   req_second_day   = '0;
   logic [ddd_pkg::MONTH_W-1:0] req_second_month = '0;
   logic [ddd_pkg::YEAR_W-1:0]  req_second_year  = '0;
   logic                        rsp_strobe;
   logic [ddd_pkg::DIFF_W-1:0]  rsp_day_difference;

   pending_word_type           pending_words[$];
   logic [ddd_pkg::DIFF_W-1:0] expected_diffs[$];
   int                         error_count = 0;
   int                         stall_cycles = 0;

   date_day_difference u_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_first_day      (req_first_day),
      .req_first_month    (req_first_month),
      .req_first_year     (req_first_year),
      .req_second_day     (req_second_day),
      .req_second_month   (req_second_month),
      .req_second_year    (req_second_year),
      .rsp_strobe         (rsp_strobe),
      .rsp_day_difference (rsp_day_difference)
   );

   always #5 clock = ~clock;

   // day number of one date: whole years, earlier months, leap day, then the day itself
   function automatic int date_day_number(int day, int month, int year);
      int  y;
      int  p;
      int  total;
      bit  is_leap;
      y = (year > ddd_pkg::MAX_YEAR) ? ddd_pkg::MAX_YEAR : year;
      total = 0;
      if (y > 0) begin
         p = y - 1;
         total = 365 * y + p / 4 - p / 100 + p / 400 + 1;
      end
      total += DAYS_BEFORE_MONTH[(month > 13) ? 13 : month];
      is_leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
      if (is_leap && month > 2) total += 1;
      return total + day;
   endfunction

   // absolute distance between the two dates, saturated to the result width
   function automatic logic [ddd_pkg::DIFF_W-1:0] predict_difference(date_pair_type d);
      int a;
      int b;
      int diff;
      a = date_day_number(d.first_day, d.first_month, d.first_year);
      b = date_day_number(d.second_day, d.second_month, d.second_year);
      diff = (a > b) ? a - b : b - a;
      if (diff > DIFF_LIMIT) diff = DIFF_LIMIT;
      return ddd_pkg::DIFF_W'(diff);
   endfunction

   function automatic date_pair_type make_pair(int d1, int m1, int y1,
                                               int d2, int m2, int y2);
      date_pair_type d;
      d.first_day    = ddd_pkg::DAY_W'(d1);
      d.first_month  = ddd_pkg::MONTH_W'(m1);
      d.first_year   = ddd_pkg::YEAR_W'(y1);
      d.second_day   = ddd_pkg::DAY_W'(d2);
      d.second_month = ddd_pkg::MONTH_W'(m2);
      d.second_year  = ddd_pkg::YEAR_W'(y2);
      return d;
   endfunction

   // mostly calendar dates, often close together; the rest any bit pattern
   function automatic date_pair_type random_pair();
      date_pair_type d;
      logic [63:0]   raw;
      int            y2;
      if ($urandom_range(9) < 3) begin
         raw = {$urandom, $urandom};
         d = raw[$bits(date_pair_type)-1:0];
      end else begin
         d.first_day    = ddd_pkg::DAY_W'($urandom_range(31, 1));
         d.first_month  = ddd_pkg::MONTH_W'($urandom_range(12, 1));
         d.first_year   = ddd_pkg::YEAR_W'($urandom_range(9999));
         d.second_day   = ddd_pkg::DAY_W'($urandom_range(31, 1));
         d.second_month = ddd_pkg::MONTH_W'($urandom_range(12, 1));
         if ($urandom_range(1)) begin
            y2 = int'(d.first_year) + int'($urandom_range(6)) - 3;
            if (y2 < 0) y2 = 0;
            if (y2 > 9999) y2 = 9999;
            d.second_year = ddd_pkg::YEAR_W'(y2);
         end else begin
            d.second_year = ddd_pkg::YEAR_W'($urandom_range(9999));
         end
      end
      return d;
   endfunction

   task automatic queue_word(date_pair_type d, int idle_pct, bit wait_for_drain);
      pending_word_type w;
      w.dates          = d;
      w.idle_pct       = idle_pct;
      w.wait_for_drain = wait_for_drain;
      pending_words.push_back(w);
   endtask

   task automatic report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   // driver: record accepted words, then present the next one or idle
   always @(posedge clock) begin : drive_words
      pending_word_type head;
      bit               accepted;
      bit               go;
      if (reset) begin
         start <= 1'b0;
      end else begin
         accepted = start && !busy;
         if (accepted) begin
            expected_diffs.push_back(predict_difference({req_first_day, req_first_month,
               req_first_year, req_second_day, req_second_month, req_second_year}));
         end
         // hold a word that was not taken
         if (!(start && !accepted)) begin
            go = 1'b0;
            if (pending_words.size() > 0) begin
               head = pending_words[0];
               if (head.wait_for_drain && (expected_diffs.size() != 0 || accepted))
                  go = 1'b0;
               else
                  go = ($urandom_range(99) >= head.idle_pct);
            end
            if (go) begin
               void'(pending_words.pop_front());
               req_first_day    <= head.dates.first_day;
               req_first_month  <= head.dates.first_month;
               req_first_year   <= head.dates.first_year;
               req_second_day   <= head.dates.second_day;
               req_second_month <= head.dates.second_month;
               req_second_year  <= head.dates.second_year;
               start            <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each strobed result with the oldest expectation
   always @(posedge clock) begin : check_results
      logic [ddd_pkg::DIFF_W-1:0] want;
      if (!reset && rsp_strobe) begin
         if (expected_diffs.size() == 0) begin
            report_mismatch($sformatf("unexpected result %0d", rsp_day_difference));
         end else begin
            want = expected_diffs.pop_front();
            if (rsp_day_difference !== want)
               report_mismatch($sformatf("day_difference expected %0d, got %0d",
                                         want, rsp_day_difference));
         end
      end
   end

   // watchdog: end the run if nothing moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("[%0t] no progress for %0d cycles", $realtime, STALL_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      int idle_pct;
      // directed: field extremes, leap rules, clamping and invalid dates
      queue_word(make_pair(0, 0, 0, 0, 0, 0), 0, 1'b0);
      queue_word(make_pair(31, 15, 16383, 31, 15, 16383), 0, 1'b0);
      queue_word(make_pair(1, 1, 0, 31, 12, 9999), 0, 1'b0);
      queue_word(make_pair(31, 12, 9999, 1, 1, 0), 0, 1'b0);
      queue_word(make_pair(0, 0, 0, 31, 15, 16383), 0, 1'b0);
      queue_word(make_pair(15, 6, 2024, 15, 6, 2024), 0, 1'b0);
      queue_word(make_pair(29, 2, 2000, 1, 3, 2000), 0, 1'b0);
      queue_word(make_pair(28, 2, 1900, 1, 3, 1900), 0, 1'b0);
      queue_word(make_pair(28, 2, 2024, 1, 3, 2024), 0, 1'b0);
      queue_word(make_pair(1, 3, 0, 28, 2, 0), 0, 1'b0);
      queue_word(make_pair(1, 1, 100, 1, 1, 101), 0, 1'b0);
      queue_word(make_pair(1, 1, 400, 1, 1, 401), 0, 1'b0);
      queue_word(make_pair(1, 1, 1, 1, 1, 0), 0, 1'b0);
      queue_word(make_pair(5, 7, 9999, 5, 7, 10000), 0, 1'b0);
      queue_word(make_pair(5, 7, 9998, 5, 7, 12345), 0, 1'b0);
      queue_word(make_pair(10, 13, 2023, 10, 14, 2023), 0, 1'b0);
      queue_word(make_pair(10, 15, 2024, 10, 1, 2025), 0, 1'b0);
      queue_word(make_pair(0, 0, 2024, 1, 1, 2024), 0, 1'b0);
      queue_word(make_pair(31, 2, 2023, 1, 3, 2023), 0, 1'b0);
      queue_word(make_pair(31, 4, 2023, 1, 5, 2023), 0, 1'b0);
      queue_word(make_pair(31, 12, 1999, 1, 1, 2000), 0, 1'b1);

      // random in three phases: light idling, heavy idling, none
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i < RANDOM_WORDS / 3)           idle_pct = 14;
         else if (i < 2 * RANDOM_WORDS / 3)  idle_pct = 74;
         else                                idle_pct = 0;
         queue_word(random_pair(), idle_pct,
                    (i % (RANDOM_WORDS / 3) == 0) || ($urandom_range(99) == 0));
      end

      // hold reset at the start, then release it
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // drain the stimulus, then the pipeline
      while (pending_words.size() != 0 || start || expected_diffs.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (expected_diffs.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_diffs.size()));
      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
